/* sv/ufg_pkg.sv */
// Shared types and constants for the friend/enemy disjoint-set engine.
// Used by the engine, the top level and the port checker; no dependencies.
package ufg_pkg;

    // Width of a person index on the ports and of the group count
    localparam int IDX_W = 10;

    // Group count after reset
    localparam logic [IDX_W-1:0] NUM_PEOPLE_RST = 10'd1023;

    // Relation kinds
    localparam logic REL_FRIEND = 1'b0;
    localparam logic REL_ENEMY  = 1'b1;

    // One input item
    typedef struct packed {
        logic             relation;
        logic [IDX_W-1:0] person_a;
        logic [IDX_W-1:0] person_b;
    } t_item;

    // One result item
    typedef struct packed {
        logic [IDX_W-1:0] group_count;
        logic             bad_index;
    } t_result;

endpackage

/* sv/ufg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read returns the contents before a write to the same address. No dependencies.
module ufg_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ufg_engine.sv */
// Sequencer for the disjoint-set engine: parent and enemy memories, one shared
// equality compare unit, find with path compression, union and group count.
// Depends on ufg_pkg and ufg_ram.
module ufg_engine #(
    parameter int MAX_PEOPLE = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ufg_pkg::IDX_W-1:0]     i_cfg_wdata,
    input  logic [ufg_pkg::IDX_W-1:0]     i_num_people,
    input  logic                          i_start,
    input  ufg_pkg::t_item                i_item,
    output logic                          o_idle,
    input  logic                          i_out_free,
    output logic                          o_done,
    output ufg_pkg::t_result              o_result
);

    import ufg_pkg::*;

    // Only indices that fit the 10-bit ports can ever be used
    localparam int Depth = (MAX_PEOPLE < (1 << IDX_W)) ? MAX_PEOPLE : (1 << IDX_W);
    localparam int AW    = $clog2(Depth);

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_E_RD    = 4'd2;
    localparam logic [3:0] S_E_CHK   = 4'd3;
    localparam logic [3:0] S_E_SET   = 4'd4;
    localparam logic [3:0] S_U1      = 4'd5;
    localparam logic [3:0] S_U2      = 4'd6;
    localparam logic [3:0] F_WALK    = 4'd7;
    localparam logic [3:0] F_COMP    = 4'd8;
    localparam logic [3:0] F_COMP_WR = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [3:0]       r_ret, n_ret;
    logic [AW-1:0]    r_clr, n_clr;
    logic [IDX_W-1:0] r_groups, n_groups;
    logic             r_side, n_side;
    logic             r_bad, n_bad;
    logic             r_rel, n_rel;
    logic [AW-1:0]    r_a, n_a;
    logic [AW-1:0]    r_b, n_b;
    logic [AW-1:0]    r_fx, n_fx;
    logic [AW-1:0]    r_root, n_root;
    logic [AW-1:0]    r_cur, n_cur;
    logic [AW-1:0]    r_rx, n_rx;
    logic [AW-1:0]    r_uy, n_uy;

    logic             p_we, e_we;
    logic [AW-1:0]    p_waddr, p_wdata, p_raddr, p_rdata;
    logic [AW-1:0]    e_waddr, e_wdata, e_raddr, e_rdata;
    logic [AW-1:0]    cmp_l, cmp_r;
    logic             cmp_eq;
    logic [AW-1:0]    self_idx, other_idx;
    logic             item_ok;

    function automatic logic person_ok(input logic [IDX_W-1:0] x,
                                       input logic [IDX_W-1:0] np);
        return (x != '0) && (x <= np) && (32'(x) < 32'(MAX_PEOPLE));
    endfunction

    ufg_ram #(.WIDTH(AW), .DEPTH(Depth)) u_parent (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    ufg_ram #(.WIDTH(AW), .DEPTH(Depth)) u_enemy (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    // Side of an enemy relation: first person, then second
    assign self_idx  = r_side ? r_b : r_a;
    assign other_idx = r_side ? r_a : r_b;

    assign item_ok = person_ok(i_item.person_a, i_num_people) &&
                     person_ok(i_item.person_b, i_num_people);

    // Shared compare unit: operand selection by state
    always_comb begin
        cmp_l = p_rdata;
        cmp_r = r_root;
        case (r_state)
            F_COMP: begin
                cmp_l = r_fx;
            end
            S_U2: begin
                cmp_l = r_rx;
            end
            default: begin
                cmp_l = p_rdata;
            end
        endcase
    end

    assign cmp_eq = (cmp_l == cmp_r);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_clr    = r_clr;
        n_groups = r_groups;
        n_side   = r_side;
        n_bad    = r_bad;
        n_rel    = r_rel;
        n_a      = r_a;
        n_b      = r_b;
        n_fx     = r_fx;
        n_root   = r_root;
        n_cur    = r_cur;
        n_rx     = r_rx;
        n_uy     = r_uy;
        p_we     = 1'b0;
        p_waddr  = r_cur;
        p_wdata  = r_root;
        p_raddr  = r_root;
        e_we     = 1'b0;
        e_waddr  = self_idx;
        e_wdata  = r_root;
        e_raddr  = self_idx;
        o_done   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rel = i_item.relation;
                    n_a   = i_item.person_a[AW-1:0];
                    n_b   = i_item.person_b[AW-1:0];
                    n_bad = !item_ok;
                    if (!item_ok) begin
                        n_state = S_DONE;
                    end else if (i_item.relation == REL_FRIEND) begin
                        // find(a), then find(b) and join
                        n_fx    = i_item.person_a[AW-1:0];
                        n_root  = i_item.person_a[AW-1:0];
                        p_raddr = i_item.person_a[AW-1:0];
                        n_uy    = i_item.person_b[AW-1:0];
                        n_ret   = S_U1;
                        n_state = F_WALK;
                    end else begin
                        n_side  = 1'b0;
                        n_state = S_E_RD;
                    end
                end
            end
            S_CLEAR: begin
                // Sweep: parent to identity, enemy to none
                p_we    = 1'b1;
                p_waddr = r_clr;
                p_wdata = r_clr;
                e_we    = 1'b1;
                e_waddr = r_clr;
                e_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(Depth - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_E_RD: begin
                e_raddr = self_idx;
                n_state = S_E_CHK;
            end
            S_E_CHK: begin
                if (e_rdata != '0) begin
                    // Join other with the recorded enemy
                    n_fx    = e_rdata;
                    n_root  = e_rdata;
                    p_raddr = e_rdata;
                    n_uy    = other_idx;
                    n_ret   = S_U1;
                end else begin
                    // Record root of other as the enemy
                    n_fx    = other_idx;
                    n_root  = other_idx;
                    p_raddr = other_idx;
                    n_ret   = S_E_SET;
                end
                n_state = F_WALK;
            end
            S_E_SET: begin
                e_we    = 1'b1;
                e_waddr = self_idx;
                e_wdata = r_root;
                if (r_rel == REL_ENEMY && !r_side) begin
                    n_side  = 1'b1;
                    n_state = S_E_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_U1: begin
                n_rx    = r_root;
                n_fx    = r_uy;
                n_root  = r_uy;
                p_raddr = r_uy;
                n_ret   = S_U2;
                n_state = F_WALK;
            end
            S_U2: begin
                // Attach first root under second when they differ
                if (!cmp_eq) begin
                    p_we    = 1'b1;
                    p_waddr = r_rx;
                    p_wdata = r_root;
                    if (r_groups != '0) begin
                        n_groups = r_groups - 1'b1;
                    end
                end
                if (r_rel == REL_ENEMY && !r_side) begin
                    n_side  = 1'b1;
                    n_state = S_E_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            F_WALK: begin
                // Follow parent links until an entry points to itself
                if (cmp_eq) begin
                    n_state = F_COMP;
                end else begin
                    n_root  = p_rdata;
                    p_raddr = p_rdata;
                end
            end
            F_COMP: begin
                if (cmp_eq) begin
                    n_state = r_ret;
                end else begin
                    p_raddr = r_fx;
                    n_cur   = r_fx;
                    n_state = F_COMP_WR;
                end
            end
            F_COMP_WR: begin
                // Point the current node at the root, advance to its old parent
                p_we    = 1'b1;
                p_waddr = r_cur;
                p_wdata = r_root;
                n_cur   = p_rdata;
                if (cmp_eq) begin
                    n_state = r_ret;
                end else begin
                    p_raddr = p_rdata;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Register write restarts the engine
        if (i_cfg_we) begin
            n_state  = S_CLEAR;
            n_clr    = '0;
            n_groups = i_cfg_wdata;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ret    <= S_IDLE;
            r_clr    <= '0;
            r_groups <= NUM_PEOPLE_RST;
            r_side   <= 1'b0;
            r_bad    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_clr    <= n_clr;
            r_groups <= n_groups;
            r_side   <= n_side;
            r_bad    <= n_bad;
        end
    end

    // Working operands
    always_ff @(posedge i_clk) begin
        r_rel  <= n_rel;
        r_a    <= n_a;
        r_b    <= n_b;
        r_fx   <= n_fx;
        r_root <= n_root;
        r_cur  <= n_cur;
        r_rx   <= n_rx;
        r_uy   <= n_uy;
    end

    assign o_idle               = (r_state == S_IDLE);
    assign o_result.group_count = r_groups;
    assign o_result.bad_index   = r_bad;

endmodule

/* sv/union_find_friend_enemy_groups_core.sv */
// Friend/enemy grouping engine: a disjoint-set union with path compression over
// people 1..num_people, one relation per input item and one result (group count,
// bad-index flag) per item. Items are handled one at a time by a sequencer that
// walks a single-port-pair parent memory, one parent link per cycle: an item
// with a bad index goes straight to its result; a friend item runs a find from
// each of the two people and a union; an enemy item runs one such find or union
// per side. Path compression keeps the chain depths short. After reset and after
// every write of num_people the engine clears both memories, one entry a cycle
// over min(MAX_PEOPLE, 1024) entries, and takes no item during that pass.
// A finished result waits in an output register; the next item may be
// accepted while it waits. Depends on ufg_pkg and ufg_engine.
module union_find_friend_enemy_groups_core #(
    parameter int MAX_PEOPLE = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ufg_pkg::IDX_W-1:0] i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_relation,
    input  logic [ufg_pkg::IDX_W-1:0] i_person_a,
    input  logic [ufg_pkg::IDX_W-1:0] i_person_b,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [ufg_pkg::IDX_W-1:0] o_group_count,
    output logic                      o_bad_index
);

    import ufg_pkg::*;

    logic [IDX_W-1:0] r_num_people;
    logic             r_out_valid, n_out_valid;
    t_result          r_out;
    t_item            item;
    t_result          eng_result;
    logic             eng_idle, eng_done, out_free;

    assign item.relation = i_relation;
    assign item.person_a = i_person_a;
    assign item.person_b = i_person_b;

    assign out_free = !r_out_valid || i_ready;

    ufg_engine #(.MAX_PEOPLE(MAX_PEOPLE)) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_num_people (r_num_people),
        .i_start      (i_valid && eng_idle),
        .i_item       (item),
        .o_idle       (eng_idle),
        .i_out_free   (out_free),
        .o_done       (eng_done),
        .o_result     (eng_result)
    );

    // Hold the number of people in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_people <= NUM_PEOPLE_RST;
        end else if (i_cfg_we) begin
            r_num_people <= i_cfg_wdata;
        end
    end

    // Output register: load on done, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (eng_done) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done) begin
            r_out <= eng_result;
        end
    end

    assign o_ready       = eng_idle;
    assign o_valid       = r_out_valid;
    assign o_group_count = r_out.group_count;
    assign o_bad_index   = r_out.bad_index;

endmodule

/* sv/ufg_checker.sv */
// Port-level checks for the friend/enemy grouping engine, bound to the top level.
// Depends on ufg_pkg and union_find_friend_enemy_groups_core.
module ufg_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_we,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [ufg_pkg::IDX_W-1:0] o_group_count,
    input logic                      o_bad_index
);

    // A result not taken holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_group_count) && $stable(o_bad_index))
        else $error("result changed while stalled");

    // An accepted item keeps the engine busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after an accepted item");

    // A register write starts the clearing pass
    a_clear_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_ready)
        else $error("ready right after a register write");

    // Reset starts the clearing pass
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("ready or valid right after reset");

endmodule

bind union_find_friend_enemy_groups_core ufg_checker u_ufg_checker (.*);

/* dv/union_find_friend_enemy_groups_core_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for union_find_friend_enemy_groups_core: a queue-fed driver, a bursty
// sender, a stalling receiver and a disjoint-set predictor that checks every result item.
// Depends on ufg_pkg and the core RTL only.
module union_find_friend_enemy_groups_core_test;
    import ufg_pkg::*;

    localparam int MAX_PEOPLE = 1024;
    localparam int IDLE_PAUSE = 16;
    localparam int TAIL_CYCLES = 64;
    localparam int LONG_HOLD = 600;
    localparam int HOLD_AFTER = 130;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_wdata = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic             i_relation = REL_FRIEND;
    logic [IDX_W-1:0] i_person_a = '0;
    logic [IDX_W-1:0] i_person_b = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [IDX_W-1:0] o_group_count;
    logic             o_bad_index;

    union_find_friend_enemy_groups_core #(
        .MAX_PEOPLE(MAX_PEOPLE)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_relation   (i_relation),
        .i_person_a   (i_person_a),
        .i_person_b   (i_person_b),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_group_count(o_group_count),
        .o_bad_index  (o_bad_index)
    );

    always #5 i_clk = ~i_clk;

    // Relations waiting to be offered, and group counts waiting to come back
    t_item   relation_q[$];
    t_result count_q[$];

    int unsigned error_count = 0;
    int unsigned results_seen = 0;
    logic        item_taken = 1'b0;

    // Shadow copy of the disjoint-set state
    logic [IDX_W-1:0] boss_of [MAX_PEOPLE];
    logic [IDX_W-1:0] foe_of [MAX_PEOPLE];
    logic [IDX_W-1:0] groups_now;
    logic [IDX_W-1:0] people_cnt;

    // Clear the forest and reload the group count
    function automatic void clear_groups();
        for (int i = 0; i < MAX_PEOPLE; i++) begin
            boss_of[i] = IDX_W'(i);
            foe_of[i] = '0;
        end
        groups_now = people_cnt;
    endfunction

    // Find the root, then point every node on the path straight at it
    function automatic logic [IDX_W-1:0] find_root(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] nxt;
        int steps;
        r = x;
        steps = 0;
        while (boss_of[r] != r && steps < MAX_PEOPLE) begin
            r = boss_of[r];
            steps++;
        end
        cur = x;
        steps = 0;
        while (cur != r && steps < MAX_PEOPLE) begin
            nxt = boss_of[cur];
            boss_of[cur] = r;
            cur = nxt;
            steps++;
        end
        return r;
    endfunction

    // Attach the root of x under the root of y
    function automatic void join_groups(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y);
        logic [IDX_W-1:0] rx;
        logic [IDX_W-1:0] ry;
        rx = find_root(x);
        ry = find_root(y);
        if (rx != ry) begin
            boss_of[rx] = ry;
            if (groups_now != 0)
                groups_now = groups_now - 1'b1;
        end
    endfunction

    // Join with the known enemy, or record the other side as the enemy
    function automatic void mark_enemy(input logic [IDX_W-1:0] self, input logic [IDX_W-1:0] other);
        if (foe_of[self] != 0)
            join_groups(foe_of[self], other);
        else
            foe_of[self] = find_root(other);
    endfunction

    function automatic bit person_ok(input logic [IDX_W-1:0] x);
        return x >= 1 && x <= people_cnt;
    endfunction

    // Apply one relation and return the group count it leaves
    function automatic t_result apply_relation(input t_item it);
        t_result res;
        res.bad_index = 1'b0;
        if (!person_ok(it.person_a) || !person_ok(it.person_b)) begin
            res.bad_index = 1'b1;
        end else if (it.relation == REL_FRIEND) begin
            join_groups(it.person_a, it.person_b);
        end else begin
            mark_enemy(it.person_a, it.person_b);
            mark_enemy(it.person_b, it.person_a);
        end
        res.group_count = groups_now;
        return res;
    endfunction

    // Sender: offer items in bursts, hold each one until it is taken
    always @(negedge i_clk) begin : drive_items
        t_item nxt_item;
        int unsigned burst_left;
        int unsigned gap_left;
        if (i_valid && !item_taken) begin
            // hold
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            i_valid <= 1'b0;
        end else if (relation_q.size() != 0) begin
            nxt_item = relation_q.pop_front();
            i_relation <= nxt_item.relation;
            i_person_a <= nxt_item.person_a;
            i_person_b <= nxt_item.person_b;
            i_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 16);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left = burst_left - 1;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver: switch between stall patterns, with one long hold-off
    always @(negedge i_clk) begin : drive_ready
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned mode;
        bit hold_done;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            i_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left = mode_left - 1;
            end
            case (mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Predict on every taken item, compare every returned result
    always @(posedge i_clk) begin : check_results
        t_item   seen_item;
        t_result want;
        item_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                seen_item.relation = i_relation;
                seen_item.person_a = i_person_a;
                seen_item.person_b = i_person_b;
                count_q.push_back(apply_relation(seen_item));
            end
            if (o_valid && i_ready) begin
                results_seen <= results_seen + 1;
                if (count_q.size() == 0) begin
                    $error("unexpected result: group_count %0d bad_index %0d",
                           o_group_count, o_bad_index);
                    error_count++;
                end else begin
                    want = count_q.pop_front();
                    if (o_group_count !== want.group_count) begin
                        $error("group_count mismatch: expected %0d, actual %0d",
                               want.group_count, o_group_count);
                        error_count++;
                    end
                    if (o_bad_index !== want.bad_index) begin
                        $error("bad_index mismatch: expected %0d, actual %0d",
                               want.bad_index, o_bad_index);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic queue_item(input logic rel, input int a, input int b);
        t_item it;
        it.relation = rel;
        it.person_a = IDX_W'(a);
        it.person_b = IDX_W'(b);
        relation_q.push_back(it);
    endtask

    // Mostly in-range people drawn from 1..span, some raw noise
    function automatic int pick_person(input int span);
        if (span < 1 || $urandom_range(0, 11) == 0)
            return $urandom_range(0, 1023);
        return $urandom_range(1, span);
    endfunction

    task automatic queue_random(input int count, input int span);
        int s;
        for (int i = 0; i < count; i++) begin
            // narrow the span now and then to build deeper chains
            s = ($urandom_range(0, 1) == 0 && span > 64) ? 64 : span;
            queue_item($urandom_range(0, 1) ? REL_ENEMY : REL_FRIEND,
                       pick_person(s), pick_person(s));
        end
    endtask

    // Drain everything in flight, then let the block settle
    task automatic wait_idle();
        while (relation_q.size() != 0 || count_q.size() != 0 || i_valid)
            @(negedge i_clk);
        repeat (IDLE_PAUSE) @(negedge i_clk);
    endtask

    // Load a new head count; this also restarts the engine
    task automatic write_people(input int n);
        wait_idle();
        i_cfg_wdata <= IDX_W'(n);
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        people_cnt = IDX_W'(n);
        clear_groups();
        @(negedge i_clk);
    endtask

    initial begin
        people_cnt = NUM_PEOPLE_RST;
        clear_groups();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset head count: extremes, self relations, enemy chaining, bad indexes
        queue_item(REL_FRIEND, 1, 1023);
        queue_item(REL_FRIEND, 1, 1);
        queue_item(REL_ENEMY, 5, 5);
        queue_item(REL_ENEMY, 2, 3);
        queue_item(REL_ENEMY, 2, 4);
        queue_item(REL_ENEMY, 4, 6);
        queue_item(REL_FRIEND, 3, 6);
        queue_item(REL_FRIEND, 0, 5);
        queue_item(REL_FRIEND, 5, 0);
        queue_item(REL_ENEMY, 0, 0);
        queue_item(REL_ENEMY, 1023, 0);
        queue_item(REL_FRIEND, 1023, 512);
        queue_item(REL_ENEMY, 1022, 1);
        queue_item(REL_FRIEND, 7, 8);
        queue_item(REL_FRIEND, 8, 9);
        queue_item(REL_FRIEND, 9, 10);
        queue_item(REL_FRIEND, 10, 7);
        queue_item(REL_FRIEND, 11, 7);
        queue_item(REL_ENEMY, 1023, 1023);
        queue_random(100, 1023);

        // Small crowd: indexes above the head count, groups collapse fast
        write_people(8);
        queue_item(REL_FRIEND, 9, 1);
        queue_item(REL_ENEMY, 1, 1023);
        queue_item(REL_FRIEND, 8, 1);
        queue_item(REL_ENEMY, 8, 8);
        queue_random(150, 8);

        // Single person
        write_people(1);
        queue_item(REL_FRIEND, 1, 1);
        queue_item(REL_ENEMY, 1, 1);
        queue_item(REL_FRIEND, 2, 1);
        queue_random(25, 1);

        // Nobody in use: every index is bad
        write_people(0);
        queue_item(REL_FRIEND, 0, 0);
        queue_item(REL_FRIEND, 1, 1);
        queue_item(REL_ENEMY, 1023, 1023);
        queue_random(10, 0);

        write_people(1023);
        queue_random(150, 1023);

        write_people(40);
        queue_random(150, 40);

        write_people(500);
        queue_random(80, 500);

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (count_q.size() != 0) begin
            $error("%0d results never arrived", count_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("union_find_friend_enemy_groups_core test passed");
        else
            $display("union_find_friend_enemy_groups_core test failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("union_find_friend_enemy_groups_core test failed");
        $finish;
    end

endmodule
